// ----- design/rfid_tag_presence_table_core_assert.svh -----
// ---------------------------------------------------------------------------
// rfid tag presence table assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge
// ---------------------------------------------------------------------------
`ifndef RFID_TAG_PRESENCE_TABLE_CORE_ASSERT_SVH
`define RFID_TAG_PRESENCE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define RTPT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rtpt_pkg.sv -----
// ---------------------------------------------------------------------------
// rtpt_pkg
// shared types and codes of the rfid tag presence table
// ---------------------------------------------------------------------------
`default_nettype none

package rtpt_pkg;

   // operation codes
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_SWEEP = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // status codes
   localparam logic [2:0] ST_UPDATED  = 3'd0;
   localparam logic [2:0] ST_NEW      = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_SWEEP    = 3'd4;
   localparam logic [2:0] ST_READ     = 3'd5;

   // frame format
   localparam logic [7:0] HDR_BYTE0   = 8'h1B;
   localparam logic [7:0] HDR_BYTE1   = 8'h39;
   localparam logic [7:0] HDR_BYTE2   = 8'h01;
   localparam logic [3:0] POS_RSSI    = 4'd7;
   localparam logic [3:0] POS_CHARGE  = 4'd9;
   localparam logic [3:0] POS_UID_LO  = 4'd10;
   localparam logic [3:0] POS_UID_HI  = 4'd13;
   localparam logic [3:0] POS_MAX     = 4'd15;
   localparam logic [4:0] MIN_LEN     = 5'd14;

   // register map
   localparam logic       REG_TIMEOUT   = 1'b0;
   localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] frame_byte;
      logic       frame_last;
      logic [2:0] read_slot;
   } rtpt_item_type;

   typedef struct packed {
      logic        good;
      logic [31:0] uid;
      logic [7:0]  rssi;
      logic [7:0]  charge;
   } rtpt_frame_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic        tag_valid;
      logic [31:0] tag_uid;
      logic [7:0]  tag_rssi;
      logic [7:0]  tag_charge;
      logic [7:0]  valid_map;
      logic [7:0]  dropped_map;
   } rtpt_result_type;

endpackage

`default_nettype wire

// ----- design/rtpt_frame_asm.sv -----
// ---------------------------------------------------------------------------
// rtpt_frame_asm
// gathers reader frame bytes: header check, byte count, rssi, charge, uid
// ---------------------------------------------------------------------------
`default_nettype none

module rtpt_frame_asm import rtpt_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           take,
   input  wire logic [7:0]     frame_byte,
   input  wire logic           frame_last,
   output rtpt_frame_type      frame
);

   logic [3:0]  pos_ff, pos_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [31:0] uid_ff, uid_in;
   logic [7:0]  rssi_ff, rssi_in;
   logic [7:0]  charge_ff, charge_in;

   logic        hdr_now;
   logic [31:0] uid_now;
   logic [7:0]  rssi_now;
   logic [7:0]  charge_now;

   always_comb begin
      hdr_now = hdr_ok_ff;
      if ((pos_ff == 4'd0 && frame_byte != HDR_BYTE0) ||
          (pos_ff == 4'd1 && frame_byte != HDR_BYTE1) ||
          (pos_ff == 4'd2 && frame_byte != HDR_BYTE2)) begin
         hdr_now = 1'b0;
      end
      rssi_now   = (pos_ff == POS_RSSI)   ? frame_byte : rssi_ff;
      charge_now = (pos_ff == POS_CHARGE) ? frame_byte : charge_ff;
      uid_now    = uid_ff;
      if (pos_ff >= POS_UID_LO && pos_ff <= POS_UID_HI) begin
         uid_now = {uid_ff[23:0], frame_byte};
      end
   end

   assign frame.good   = hdr_now && ({1'b0, pos_ff} >= (MIN_LEN - 5'd1));
   assign frame.uid    = uid_now;
   assign frame.rssi   = rssi_now;
   assign frame.charge = charge_now;

   always_comb begin
      pos_in    = pos_ff;
      hdr_ok_in = hdr_ok_ff;
      uid_in    = uid_ff;
      rssi_in   = rssi_ff;
      charge_in = charge_ff;
      if (take) begin
         if (frame_last) begin
            // every frame end starts over, good or not
            pos_in    = 4'd0;
            hdr_ok_in = 1'b1;
            uid_in    = 32'd0;
            rssi_in   = 8'd0;
            charge_in = 8'd0;
         end else begin
            pos_in    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 4'd1;
            hdr_ok_in = hdr_now;
            uid_in    = uid_now;
            rssi_in   = rssi_now;
            charge_in = charge_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         hdr_ok_ff <= 1'b1;
         uid_ff    <= 32'd0;
         rssi_ff   <= 8'd0;
         charge_ff <= 8'd0;
      end else begin
         pos_ff    <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
         uid_ff    <= uid_in;
         rssi_ff   <= rssi_in;
         charge_ff <= charge_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/rtpt_slot_table.sv -----
// ---------------------------------------------------------------------------
// rtpt_slot_table
// tag slots with parallel uid lookup, free-slot claim, age sweep and read
// ---------------------------------------------------------------------------
`default_nettype none

module rtpt_slot_table import rtpt_pkg::*; #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire rtpt_item_type   item,
   input  wire rtpt_frame_type  frame,
   input  wire logic [31:0]     timeout,
   output logic                 has_result,
   output rtpt_result_type      result
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [4:0] SLOT_COUNT_V = 5'(SLOT_COUNT);

   logic [SLOT_COUNT-1:0] live_ff, live_in;
   logic [31:0]           tick_ff, tick_in;
   logic [31:0]           uid_ff    [SLOT_COUNT];
   logic [7:0]            rssi_ff   [SLOT_COUNT];
   logic [7:0]            charge_ff [SLOT_COUNT];
   logic [31:0]           seen_ff   [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] match;
   logic [SLOT_COUNT-1:0] dropped;
   logic [IDX_W-1:0]      hit_idx, free_idx, wr_idx, rd_idx;
   logic                  hit, free_any, fresh;
   logic                  frame_end, frame_wr, sweep, rd_in_range, rd_live;
   logic [15:0]           live_pad, dropped_pad;

   // lowest matching live slot and lowest free slot
   always_comb begin
      hit      = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         match[i] = live_ff[i] && (uid_ff[i] == frame.uid);
         if (match[i]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!live_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         dropped[i] = live_ff[i] && ((tick_ff - seen_ff[i]) > timeout);
      end
   end

   assign fresh     = !hit;
   assign wr_idx    = hit ? hit_idx : free_idx;
   assign frame_end = fire && item.operation == OP_FRAME && item.frame_last;
   assign frame_wr  = frame_end && frame.good && (hit || free_any);
   assign sweep     = fire && item.operation == OP_SWEEP;

   always_comb begin
      live_in = live_ff;
      tick_in = tick_ff;
      if (fire && item.operation == OP_TICK) begin
         tick_in = tick_ff + 32'd1;
      end
      if (sweep) begin
         live_in = live_ff & ~dropped;
      end
      if (frame_wr && fresh) begin
         live_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         tick_ff <= 32'd0;
      end else begin
         live_ff <= live_in;
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (sweep && dropped[i]) begin
            uid_ff[i]    <= 32'd0;
            rssi_ff[i]   <= 8'd0;
            charge_ff[i] <= 8'd0;
            seen_ff[i]   <= 32'd0;
         end else if (frame_wr && wr_idx == IDX_W'(i)) begin
            if (fresh) begin
               uid_ff[i] <= frame.uid;
            end
            rssi_ff[i]   <= frame.rssi;
            charge_ff[i] <= frame.charge;
            seen_ff[i]   <= tick_ff;
         end
      end
   end

   assign rd_in_range = {2'b00, item.read_slot} < SLOT_COUNT_V;
   assign rd_idx      = IDX_W'(item.read_slot);
   assign rd_live     = rd_in_range && live_ff[rd_idx];

   // maps are reported on eight bits whatever the slot count
   assign live_pad    = 16'(live_in);
   assign dropped_pad = 16'(sweep ? dropped : '0);

   always_comb begin
      has_result         = 1'b0;
      result             = '0;
      result.valid_map   = live_pad[7:0];
      unique case (item.operation)
         OP_FRAME: begin
            has_result = item.frame_last;
            if (!frame.good) begin
               result.status = ST_REJECTED;
            end else if (!(hit || free_any)) begin
               result.status     = ST_FULL;
               result.tag_uid    = frame.uid;
               result.tag_rssi   = frame.rssi;
               result.tag_charge = frame.charge;
            end else begin
               result.status     = fresh ? ST_NEW : ST_UPDATED;
               result.slot       = 3'(wr_idx);
               result.tag_valid  = 1'b1;
               result.tag_uid    = frame.uid;
               result.tag_rssi   = frame.rssi;
               result.tag_charge = frame.charge;
            end
         end
         OP_TICK: begin
            has_result = 1'b0;
         end
         OP_SWEEP: begin
            has_result         = 1'b1;
            result.status      = ST_SWEEP;
            result.dropped_map = dropped_pad[7:0];
         end
         OP_READ: begin
            has_result    = 1'b1;
            result.status = ST_READ;
            result.slot   = item.read_slot;
            if (rd_live) begin
               result.tag_valid  = 1'b1;
               result.tag_uid    = uid_ff[rd_idx];
               result.tag_rssi   = rssi_ff[rd_idx];
               result.tag_charge = charge_ff[rd_idx];
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/rfid_tag_presence_table_core.sv -----
// a word accepted on req passes through the input register and the result register
// before it appears on rsp; throughput: one word per cycle while rsp is not stalled;
// each word is settled from its input register through the parallel slot comparators
// into the result register; ticks and non-final frame bytes give no rsp word
// reset: synchronous, active high; clears the table, tick count, frame state and the
// pipeline valids, and sets the timeout to 5000 ticks
// ---------------------------------------------------------------------------
// rfid_tag_presence_table_core
// presence table of rfid tags fed by reader frames, with tick, sweep and read
// ---------------------------------------------------------------------------
`default_nettype none

`include "rfid_tag_presence_table_core_assert.svh"

module rfid_tag_presence_table_core import rtpt_pkg::*; #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: operation[1:0], frame_byte[9:2], read_slot[12:10], zero pad
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        req_tlast,
   // rsp_tdata: status[2:0], slot[5:3], tag_valid[6], tag_uid[38:7],
   // tag_rssi[46:39], tag_charge[54:47], valid_map[62:55], dropped_map[70:63], pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic            in_valid_ff, in_valid_in;
   rtpt_item_type   in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rtpt_result_type rsp_data_ff;
   logic [31:0]     timeout_ff;

   logic            fire;
   logic            has_result;
   rtpt_result_type result;
   rtpt_frame_type  frame;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TIMEOUT) ? timeout_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_TIMEOUT) begin
         timeout_ff <= csr_pwdata;
      end
   end

   // input register, then one processing step into the result register
   assign fire        = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (fire) begin
         rsp_valid_in = has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.operation  <= req_tdata[1:0];
         in_item_ff.frame_byte <= req_tdata[9:2];
         in_item_ff.read_slot  <= req_tdata[12:10];
         in_item_ff.frame_last <= req_tlast;
      end
      if (fire && has_result) begin
         rsp_data_ff <= result;
      end
   end

   rtpt_frame_asm u_frame_asm (
      .clock      (clock),
      .reset      (reset),
      .take       (fire && in_item_ff.operation == OP_FRAME),
      .frame_byte (in_item_ff.frame_byte),
      .frame_last (in_item_ff.frame_last),
      .frame      (frame)
   );

   rtpt_slot_table #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_slot_table (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_item_ff),
      .frame      (frame),
      .timeout    (timeout_ff),
      .has_result (has_result),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        rsp_data_ff.dropped_map,
                        rsp_data_ff.valid_map,
                        rsp_data_ff.tag_charge,
                        rsp_data_ff.tag_rssi,
                        rsp_data_ff.tag_uid,
                        rsp_data_ff.tag_valid,
                        rsp_data_ff.slot,
                        rsp_data_ff.status};

   `RTPT_ASSERT_NEXT(a_stall_holds_input, clock, reset,
      in_valid_ff && rsp_valid_ff && !rsp_tready, in_valid_ff,
      "pending word lost while result stalled")
   `RTPT_ASSERT_IMPL(a_dropped_not_live, clock, reset,
      rsp_valid_ff, (rsp_data_ff.dropped_map & rsp_data_ff.valid_map) == 8'd0,
      "swept slot still marked live")
   `RTPT_ASSERT_IMPL(a_read_live_in_map, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == ST_READ && rsp_data_ff.tag_valid,
      rsp_data_ff.valid_map[rsp_data_ff.slot],
      "live slot read but missing from valid map")

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench of the rfid tag presence table: a short table of
// directed words, then phases of random reader frames, ticks, sweeps and
// reads under several offline timeouts, scored against a local table model
// ---------------------------------------------------------------------------
module tb;
   import rtpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SLOTS        = 8;
   localparam int          PHASES       = 6;
   localparam int          PHASE_ITEMS  = 320;
   localparam int          UID_POOL     = 12;
   localparam int          LONG_HOLD    = 150;
   localparam int          SETTLE       = 4;
   localparam int          DRAIN        = 10;
   localparam int          STALL_LIMIT  = 2000;
   localparam logic [2:0]  TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
   localparam logic [31:0] PHASE_TIMEOUT [PHASES] =
      '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd25, 32'd60, 32'd0};

   localparam rtpt_result_type NO_REPORT = '0;

   typedef struct packed {
      rtpt_item_type   item;
      logic            typed;
      rtpt_result_type report;
   } directed_row_type;

   // rows with typed reports are read straight off the reset state
   localparam directed_row_type DIRECTED [22] = '{
      '{'{OP_READ,  8'h00, 1'b0, 3'd0}, 1'b1,
        '{ST_READ, 3'd0, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{OP_READ,  8'hFF, 1'b1, 3'd7}, 1'b1,
        '{ST_READ, 3'd7, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{OP_SWEEP, 8'hFF, 1'b1, 3'd7}, 1'b1,
        '{ST_SWEEP, 3'd0, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{OP_FRAME, 8'hFF, 1'b1, 3'd0}, 1'b1,
        '{ST_REJECTED, 3'd0, 1'b0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00}},
      // good frame: rssi ff, charge 00, uid ffffffff
      '{'{OP_FRAME, 8'h1B, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'h39, 1'b0, 3'd7}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'h01, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'h00, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'h00, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hAA, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'h00, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_FRAME, 8'hFF, 1'b1, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_TICK,  8'h55, 1'b1, 3'd5}, 1'b0, NO_REPORT},
      '{'{OP_READ,  8'h00, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_SWEEP, 8'h00, 1'b0, 3'd0}, 1'b0, NO_REPORT},
      '{'{OP_READ,  8'h00, 1'b0, 3'd1}, 1'b0, NO_REPORT}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // operation, frame_byte, read_slot, zero pad
   logic        req_tlast;    // frame_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // status, slot, tag_valid, tag_uid, tag_rssi,
                              // tag_charge, valid_map, dropped_map, zero pad
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // table model
   logic [SLOTS-1:0] live;
   logic [31:0]      slot_uid     [SLOTS];
   logic [7:0]       slot_rssi    [SLOTS];
   logic [7:0]       slot_charge  [SLOTS];
   logic [31:0]      slot_seen    [SLOTS];
   logic [31:0]      tick_count;
   logic [3:0]       frame_pos;
   logic             header_good;
   logic [7:0]       frame_rssi;
   logic [7:0]       frame_charge;
   logic [31:0]      frame_uid;
   logic [31:0]      offline_limit;

   rtpt_result_type reports_due [$];
   logic [31:0]     uid_pool [UID_POOL];
   int              items_sent;
   int              mismatches;
   bit              quiet;
   bit              long_hold_req;

   rfid_tag_presence_table_core #(.SLOT_COUNT(SLOTS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit presence_step(input rtpt_item_type it, output rtpt_result_type rep);
      logic [31:0] uid;
      logic [31:0] age;
      logic [7:0]  rssi;
      logic [7:0]  charge;
      logic [7:0]  dropped;
      bit          good;
      bit          found;
      bit          fresh;
      int          idx;
      int          i;
      rep = '0;
      dropped = '0;
      case (it.operation)
         OP_FRAME: begin
            if ((frame_pos == 4'd0 && it.frame_byte != HDR_BYTE0) ||
                (frame_pos == 4'd1 && it.frame_byte != HDR_BYTE1) ||
                (frame_pos == 4'd2 && it.frame_byte != HDR_BYTE2))
               header_good = 1'b0;
            if (frame_pos == POS_RSSI)
               frame_rssi = it.frame_byte;
            else if (frame_pos == POS_CHARGE)
               frame_charge = it.frame_byte;
            else if (frame_pos >= POS_UID_LO && frame_pos <= POS_UID_HI)
               frame_uid = {frame_uid[23:0], it.frame_byte};
            if (!it.frame_last) begin
               if (frame_pos != POS_MAX)
                  frame_pos++;
               return 1'b0;
            end
            good = header_good && ({1'b0, frame_pos} + 5'd1 >= MIN_LEN);
            uid = frame_uid;
            rssi = frame_rssi;
            charge = frame_charge;
            // frame state returns to reset whatever the outcome
            frame_pos = '0;
            header_good = 1'b1;
            frame_rssi = '0;
            frame_charge = '0;
            frame_uid = '0;
            if (!good) begin
               rep.status = ST_REJECTED;
            end else begin
               found = 1'b0;
               fresh = 1'b0;
               idx = 0;
               for (i = 0; i < SLOTS; i++)
                  if (!found && live[i] && slot_uid[i] == uid) begin
                     idx = i;
                     found = 1'b1;
                  end
               for (i = 0; i < SLOTS; i++)
                  if (!found && !live[i]) begin
                     idx = i;
                     found = 1'b1;
                     fresh = 1'b1;
                  end
               rep.tag_uid = uid;
               rep.tag_rssi = rssi;
               rep.tag_charge = charge;
               if (!found) begin
                  rep.status = ST_FULL;
               end else begin
                  if (fresh) begin
                     live[idx] = 1'b1;
                     slot_uid[idx] = uid;
                  end
                  slot_rssi[idx] = rssi;
                  slot_charge[idx] = charge;
                  slot_seen[idx] = tick_count;
                  rep.status = fresh ? ST_NEW : ST_UPDATED;
                  rep.slot = 3'(idx);
                  rep.tag_valid = 1'b1;
               end
            end
         end
         OP_TICK: begin
            tick_count++;
            return 1'b0;
         end
         OP_SWEEP: begin
            for (i = 0; i < SLOTS; i++) begin
               age = tick_count - slot_seen[i];
               if (live[i] && age > offline_limit) begin
                  live[i] = 1'b0;
                  dropped[i] = 1'b1;
                  slot_uid[i] = '0;
                  slot_rssi[i] = '0;
                  slot_charge[i] = '0;
                  slot_seen[i] = '0;
               end
            end
            rep.status = ST_SWEEP;
            rep.dropped_map = dropped;
         end
         default: begin
            rep.status = ST_READ;
            rep.slot = it.read_slot;
            if (live[it.read_slot]) begin
               rep.tag_valid = 1'b1;
               rep.tag_uid = slot_uid[it.read_slot];
               rep.tag_rssi = slot_rssi[it.read_slot];
               rep.tag_charge = slot_charge[it.read_slot];
            end
         end
      endcase
      rep.valid_map = 8'(live);
      return 1'b1;
   endfunction

   function automatic void field_check(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_report(input logic [71:0] d);
      rtpt_result_type want;
      if (reports_due.size() == 0) begin
         $error("rsp word with nothing expected: 'h%0h", d);
         mismatches++;
         return;
      end
      want = reports_due.pop_front();
      field_check("status", 32'(want.status), 32'(d[2:0]));
      field_check("slot", 32'(want.slot), 32'(d[5:3]));
      field_check("tag_valid", 32'(want.tag_valid), 32'(d[6]));
      field_check("tag_uid", want.tag_uid, d[38:7]);
      field_check("tag_rssi", 32'(want.tag_rssi), 32'(d[46:39]));
      field_check("tag_charge", 32'(want.tag_charge), 32'(d[54:47]));
      field_check("valid_map", 32'(want.valid_map), 32'(d[62:55]));
      field_check("dropped_map", 32'(want.dropped_map), 32'(d[70:63]));
   endfunction

   function automatic rtpt_item_type make_item(input logic [1:0] op);
      rtpt_item_type it;
      it.operation = op;
      it.frame_byte = 8'($urandom);
      it.frame_last = 1'($urandom);
      it.read_slot = 3'($urandom);
      return it;
   endfunction

   task automatic send_item(input rtpt_item_type it, input bit typed = 1'b0,
                            input rtpt_result_type typed_report = '0);
      rtpt_result_type rep;
      if (!quiet && $urandom_range(0, 11) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, it.read_slot, it.frame_byte, it.operation};
      req_tlast <= it.frame_last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (presence_step(it, rep))
         reports_due.push_back(typed ? typed_report : rep);
   endtask

   task automatic send_frame(input bit broken);
      logic [7:0]    frame_bytes [$];
      logic [31:0]   uid;
      rtpt_item_type it;
      int            len;
      int            i;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 21) : 14;
      uid = ($urandom_range(0, 9) == 0) ? $urandom : uid_pool[$urandom_range(0, UID_POOL - 1)];
      for (i = 0; i < len; i++)
         frame_bytes.push_back(8'($urandom));
      frame_bytes[0] = HDR_BYTE0;
      frame_bytes[1] = HDR_BYTE1;
      frame_bytes[2] = HDR_BYTE2;
      frame_bytes[10] = uid[31:24];
      frame_bytes[11] = uid[23:16];
      frame_bytes[12] = uid[15:8];
      frame_bytes[13] = uid[7:0];
      if (broken) begin
         if ($urandom_range(0, 1) == 1) begin
            i = $urandom_range(0, 2);
            frame_bytes[i] = frame_bytes[i] ^ 8'(1 << $urandom_range(0, 7));
         end else begin
            len = $urandom_range(1, 13);
            while (frame_bytes.size() > len)
               void'(frame_bytes.pop_back());
         end
      end
      foreach (frame_bytes[k]) begin
         // other operations may land in the middle of a frame
         if ($urandom_range(0, 24) == 0)
            send_item(make_item(2'($urandom_range(1, 3))));
         it = make_item(OP_FRAME);
         it.frame_byte = frame_bytes[k];
         it.frame_last = (k == frame_bytes.size() - 1);
         send_item(it);
      end
   endtask

   task automatic program_timeout(input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= TIMEOUT_ADDR;
      csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      offline_limit = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("offline_timeout_ticks: expected 'h%0h, actual 'h%0h", value, csr_prdata);
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, one long hold on request
   initial begin : report_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready)
               check_report(rsp_tdata);
            if (long_hold_req) begin
               long_hold_req = 1'b0;
               stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 13) == 0) begin
               stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("** rfid_tag_presence_table_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int phase_end;
      int pick;
      int i;
      live = '0;
      for (i = 0; i < SLOTS; i++) begin
         slot_uid[i] = '0;
         slot_rssi[i] = '0;
         slot_charge[i] = '0;
         slot_seen[i] = '0;
      end
      tick_count = '0;
      frame_pos = '0;
      header_good = 1'b1;
      frame_rssi = '0;
      frame_charge = '0;
      frame_uid = '0;
      offline_limit = TIMEOUT_RESET;
      items_sent = 0;
      mismatches = 0;
      quiet = 1'b0;
      long_hold_req = 1'b0;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r])
         send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].report);

      for (phase = 0; phase < PHASES; phase++) begin
         // table must be idle before the timeout changes
         req_tvalid <= 1'b0;
         while (reports_due.size() != 0) @(posedge clock);
         repeat (SETTLE) @(posedge clock);
         program_timeout((phase == PHASES - 1) ? 32'($urandom_range(0, 40))
                                               : PHASE_TIMEOUT[phase]);
         uid_pool[0] = 32'h0000_0000;
         uid_pool[1] = 32'hFFFF_FFFF;
         for (i = 2; i < UID_POOL; i++)
            uid_pool[i] = $urandom;
         quiet = (phase == PHASES - 1);
         if (phase == 1)
            long_hold_req = 1'b1;
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
               send_frame(1'b0);
            else if (pick < 53)
               send_frame(1'b1);
            else if (pick < 73)
               repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6))
                  send_item(make_item(OP_TICK));
            else if (pick < 83)
               send_item(make_item(OP_SWEEP));
            else if (pick < 95)
               send_item(make_item(OP_READ));
            else
               send_item(make_item(2'($urandom)));
         end
      end

      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("** rfid_tag_presence_table_core: PASSED **");
      else
         $display("** rfid_tag_presence_table_core: FAILED **");
      $finish;
   end

endmodule
